// File: design/assert_macros.svh
// Concurrent assertion helpers for the design folder.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising edge outside reset.
`define ASSERT_CLKD(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Checked on every rising edge, reset included.
`define ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// File: design/nsf_pkg.sv
`default_nettype none

package nsf_pkg;

  localparam int MAX_LEN   = 128;
  localparam int NUM_SLOTS = 4;

  // Fixed field widths of the channels.
  localparam int BYTE_W = 8;
  localparam int POS_W  = 7;
  localparam int SLT_W  = 2;
  localparam int CIDX_W = 2;

  // Internal widths derived from the sizing constants.
  localparam int IDX_W  = $clog2(MAX_LEN);
  localparam int LIM_W  = $clog2(MAX_LEN + 1);
  localparam int SLOT_W = $clog2(NUM_SLOTS);

  typedef enum logic [CIDX_W-1:0] {
    CFG_START_CHAR = 2'd0,
    CFG_END_FIRST  = 2'd1,
    CFG_END_SECOND = 2'd2,
    CFG_BUF_LENGTH = 2'd3
  } cfg_idx_t;

  localparam logic [BYTE_W-1:0] START_CHAR_RST = 8'd36;
  localparam logic [BYTE_W-1:0] END_FIRST_RST  = 8'd13;
  localparam logic [BYTE_W-1:0] END_SECOND_RST = 8'd10;
  localparam logic [BYTE_W-1:0] BUF_LENGTH_RST = 8'd128;

  typedef struct packed {
    logic [BYTE_W-1:0] start_char;
    logic [BYTE_W-1:0] end_first;
    logic [BYTE_W-1:0] end_second;
    logic [BYTE_W-1:0] buf_length;
  } cfg_t;

  typedef struct packed {
    logic [BYTE_W-1:0] data_byte;
    logic [POS_W-1:0]  position;
    logic [SLT_W-1:0]  slot;
    logic              restarted;
    logic              overflowed;
    logic              complete;
    logic [POS_W-1:0]  msg_length;
  } result_t;

endpackage

`default_nettype wire

// File: design/nmea_sentence_framer.sv
// NMEA sentence framer.
// Input channel (in_valid/in_ready/in_rx_byte): one received byte per transfer.
// Bytes are ignored until start_char opens a sentence; every byte of a sentence
// then comes out on the result channel (out_valid/out_ready) with its buffer
// position and ring slot. A start_char inside a sentence restarts it at
// position 0 (out_restarted). Reaching buf_length discards the sentence
// (out_overflowed). end_first followed by end_second completes it, reports
// out_msg_length and advances to the next slot.
// Configuration: cfg_we writes cfg_wdata to register cfg_index (0 start_char,
// 1 end_first, 2 end_second, 3 buf_length); write only while the block is idle.
// A byte taken into the input register moves on to the result register, which drives the result channel.
// Throughput: one byte per cycle while out_ready stays high; the input register and the result
// register each take a new transfer in the cycle the next stage frees it.
// Reset (rst_n low, synchronous) empties both registers, restores the default
// registers and returns the framer to idle in slot 0.
// A stalled receiver holds the result; one more byte waits in the input
// register, then in_ready drops until out_ready returns.
`default_nettype none

`include "assert_macros.svh"

module nmea_sentence_framer
  import nsf_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic [BYTE_W-1:0] in_rx_byte,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic [BYTE_W-1:0]      out_data_byte,
  output logic [POS_W-1:0]       out_position,
  output logic [SLT_W-1:0]       out_slot,
  output logic                   out_restarted,
  output logic                   out_overflowed,
  output logic                   out_complete,
  output logic [POS_W-1:0]       out_msg_length,
  input  wire logic              cfg_we,
  input  wire logic [CIDX_W-1:0] cfg_index,
  input  wire logic [BYTE_W-1:0] cfg_wdata
);

  cfg_t              cfg_r;
  logic              s1_valid_r, s1_valid_nxt;
  logic [BYTE_W-1:0] s1_byte_r;
  logic              out_valid_r, out_valid_nxt;
  result_t           out_r;
  logic              out_free;
  logic              advance;
  logic              res_valid;
  result_t           res;

  nsf_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (advance),
    .rx_byte   (s1_byte_r),
    .cfg       (cfg_r),
    .res_valid (res_valid),
    .res       (res)
  );

  always_comb begin
    out_free = !out_valid_r || out_ready;
    advance  = s1_valid_r && out_free;
    in_ready = !s1_valid_r || advance;

    s1_valid_nxt = in_ready ? in_valid : s1_valid_r;

    if (advance) begin
      out_valid_nxt = res_valid;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r       <= 1'b0;
      out_valid_r      <= 1'b0;
      cfg_r.start_char <= START_CHAR_RST;
      cfg_r.end_first  <= END_FIRST_RST;
      cfg_r.end_second <= END_SECOND_RST;
      cfg_r.buf_length <= BUF_LENGTH_RST;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_START_CHAR: cfg_r.start_char <= cfg_wdata;
          CFG_END_FIRST:  cfg_r.end_first  <= cfg_wdata;
          CFG_END_SECOND: cfg_r.end_second <= cfg_wdata;
          CFG_BUF_LENGTH: cfg_r.buf_length <= cfg_wdata;
          default: ;
        endcase
      end
    end
    // payload: load on transfer, hold otherwise
    if (in_valid && in_ready) begin
      s1_byte_r <= in_rx_byte;
    end
    if (advance) begin
      out_r <= res;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_data_byte  = out_r.data_byte;
  assign out_position   = out_r.position;
  assign out_slot       = out_r.slot;
  assign out_restarted  = out_r.restarted;
  assign out_overflowed = out_r.overflowed;
  assign out_complete   = out_r.complete;
  assign out_msg_length = out_r.msg_length;

  `ASSERT_CLKD(a_restart_at_zero, out_valid && out_restarted |-> out_position == '0, "restart not at position 0")
  `ASSERT_CLKD(a_len_only_complete, out_valid && !out_complete |-> out_msg_length == '0, "length without completion")
  `ASSERT_CLKD(a_len_nonzero, out_valid && out_complete && !out_overflowed |-> out_msg_length != '0, "completed sentence with zero length")
  `ASSERT_CLKD(a_ready_when_free, !out_valid || out_ready |-> in_ready, "input stalled while result stage free")

endmodule

`default_nettype wire

// File: design/nsf_core.sv
`default_nettype none

module nsf_core
  import nsf_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              step,
  input  wire logic [BYTE_W-1:0] rx_byte,
  input  wire cfg_t              cfg,
  output logic                   res_valid,
  output result_t                res
);

  localparam int CMP_W = (LIM_W > BYTE_W) ? LIM_W : BYTE_W;

  logic              in_sentence_r, in_sentence_nxt;
  logic [BYTE_W-1:0] prev_byte_r, prev_byte_nxt;
  logic [IDX_W-1:0]  write_index_r, write_index_nxt;
  logic [SLOT_W-1:0] slot_r, slot_nxt;

  logic [CMP_W-1:0]  buf_ext;
  logic [LIM_W-1:0]  limit;
  logic              hit_start;
  logic              restarted;
  logic [IDX_W-1:0]  idx_rs;
  logic [IDX_W-1:0]  idx_pos;
  logic [LIM_W-1:0]  idx_inc;
  logic              overflowed;
  logic              complete;
  logic [LIM_W-1:0]  fill;
  logic [SLOT_W-1:0] slot_adv;

  always_comb begin
    buf_ext = CMP_W'(cfg.buf_length);
    if (buf_ext == '0 || buf_ext > CMP_W'(MAX_LEN)) begin
      limit = LIM_W'(MAX_LEN);
    end else begin
      limit = LIM_W'(buf_ext);
    end

    hit_start = (rx_byte == cfg.start_char);
    restarted = in_sentence_r && hit_start;
    res_valid = in_sentence_r || hit_start;

    idx_rs  = restarted ? '0 : write_index_r;
    // wrap a stale index left over from a larger buffer length
    idx_pos = (LIM_W'(idx_rs) >= limit) ? '0 : idx_rs;
    idx_inc = LIM_W'(idx_pos) + LIM_W'(1);

    overflowed = (idx_inc == limit);
    fill       = overflowed ? '0 : idx_inc;
    complete   = (rx_byte == cfg.end_second) && (prev_byte_r == cfg.end_first);

    slot_adv = (slot_r == SLOT_W'(NUM_SLOTS - 1)) ? '0 : slot_r + SLOT_W'(1);

    res.data_byte  = rx_byte;
    res.position   = POS_W'(idx_pos);
    res.slot       = SLT_W'(slot_r);
    res.restarted  = restarted;
    res.overflowed = overflowed;
    res.complete   = complete;
    res.msg_length = complete ? POS_W'(fill) : '0;

    in_sentence_nxt = in_sentence_r;
    prev_byte_nxt   = prev_byte_r;
    write_index_nxt = write_index_r;
    slot_nxt        = slot_r;
    if (step && res_valid) begin
      prev_byte_nxt   = rx_byte;
      in_sentence_nxt = !(overflowed || complete);
      write_index_nxt = (overflowed || complete) ? '0 : IDX_W'(idx_inc);
      if (complete) begin
        slot_nxt = slot_adv;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_sentence_r <= 1'b0;
      prev_byte_r   <= '0;
      write_index_r <= '0;
      slot_r        <= '0;
    end else begin
      in_sentence_r <= in_sentence_nxt;
      prev_byte_r   <= prev_byte_nxt;
      write_index_r <= write_index_nxt;
      slot_r        <= slot_nxt;
    end
  end

endmodule

`default_nettype wire
